// File: design/assert_macros.svh
// Assertion helpers for the frame table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, masked while reset is asserted
`define PSTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pstc: assertion failed");
// clocked check that also holds through reset
`define PSTC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("pstc: assertion failed");
`else
`define PSTC_ASSERT(lbl, prop)
`define PSTC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: design/pstc_pkg.sv
package pstc_pkg;

    localparam int FRAMES    = 64;
    localparam int PAGE_BITS = 20;
    localparam int SLOT_W    = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int STEP_W    = $clog2(2 * FRAMES + 1);

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_ACCESS = 2'd2;
    localparam logic [1:0] ACT_PIN    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PINNED = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    // one age-list entry
    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [PAGE_BITS-1:0] page;
        logic                 mapped;
        logic                 pinned;
        logic                 accessed;
        logic                 dirty;
    } pstc_entry_t;

    // chain control, broadcast to every cell
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [SLOT_W-1:0] load_idx;
        pstc_entry_t       ins;
    } pstc_shift_t;

endpackage

// File: design/pstc_cell.sv
module pstc_cell
    import pstc_pkg::*;
(
    input  logic              aclk,
    input  logic [SLOT_W-1:0] cell_idx,
    input  pstc_shift_t       ctl,
    input  pstc_entry_t       right_in,
    output pstc_entry_t       entry_out
);

    pstc_entry_t ent_reg;
    pstc_entry_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.load && (ctl.load_idx == cell_idx)) begin
            ent_next = ctl.ins;
        end else if (ctl.shift) begin
            ent_next = right_in;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign entry_out = ent_reg;

endmodule

// File: design/pstc_ctl.sv
`include "assert_macros.svh"

module pstc_ctl
    import pstc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,
    input  pstc_entry_t head,
    input  pstc_entry_t second,
    output pstc_shift_t shctl
);

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_SCAN, S_RESTORE, S_ROTATE, S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           act_reg, act_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 fm_reg, fm_next;
    logic                 wr_reg, wr_next;
    logic                 pin_reg, pin_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [FRAMES-1:0]    used_reg, used_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     rot_len_reg, rot_len_next;
    logic [SLOT_W-1:0]    start_reg, start_next;
    logic [SLOT_W-1:0]    fcnt_reg, fcnt_next;
    logic [1:0]           res_st_reg, res_st_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 res_ev_reg, res_ev_next;
    logic [PAGE_BITS-1:0] res_page_reg, res_page_next;
    logic                 res_wb_reg, res_wb_next;
    logic                 res_sw_reg, res_sw_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_data_reg, m_data_next;
    logic [1:0]           m_user_reg, m_user_next;

    logic [1:0]           in_act;
    logic [SLOT_W-1:0]    in_slot;
    pstc_entry_t          fresh;
    pstc_entry_t          kept;

    assign in_act  = s_tuser;
    assign in_slot = s_tdata[SLOT_W-1:0];

    always_comb begin
        fresh          = '0;
        fresh.page     = page_reg;
        fresh.mapped   = fm_reg;
    end

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        slot_next     = slot_reg;
        page_next     = page_reg;
        fm_next       = fm_reg;
        wr_next       = wr_reg;
        pin_next      = pin_reg;
        count_next    = count_reg;
        used_next     = used_reg;
        step_next     = step_reg;
        rot_len_next  = rot_len_reg;
        start_next    = start_reg;
        fcnt_next     = fcnt_reg;
        res_st_next   = res_st_reg;
        res_slot_next = res_slot_reg;
        res_ev_next   = res_ev_reg;
        res_page_next = res_page_reg;
        res_wb_next   = res_wb_reg;
        res_sw_next   = res_sw_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        kept          = head;
        shctl         = '0;
        shctl.ins     = head;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next      = in_act;
                    slot_next     = in_slot;
                    page_next     = s_tdata[SLOT_W +: PAGE_BITS];
                    fm_next       = s_tdata[26];
                    wr_next       = s_tdata[27];
                    pin_next      = s_tdata[28];
                    res_st_next   = ST_OK;
                    res_slot_next = '0;
                    res_ev_next   = 1'b0;
                    res_page_next = '0;
                    res_wb_next   = 1'b0;
                    res_sw_next   = 1'b0;
                    step_next     = '0;
                    fcnt_next     = '0;
                    rot_len_next  = count_reg;
                    start_next    = head.slot;
                    if (in_act == ACT_ALLOC) begin
                        if (count_reg == CNT_W'(FRAMES)) begin
                            state_next = S_SCAN;
                        end else begin
                            state_next = S_SWEEP;
                        end
                    end else if ((CNT_W'(in_slot) >= CNT_W'(FRAMES)) ||
                                 !used_reg[in_slot]) begin
                        res_st_next = ST_UNUSED;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_ROTATE;
                    end
                end
            end
            S_SWEEP: begin
                // lowest free slot, one slot a cycle
                if (!used_reg[fcnt_reg]) begin
                    shctl.load          = 1'b1;
                    shctl.load_idx      = count_reg[SLOT_W-1:0];
                    shctl.ins           = fresh;
                    shctl.ins.slot      = fcnt_reg;
                    used_next[fcnt_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    res_slot_next       = fcnt_reg;
                    state_next          = S_FINISH;
                end else begin
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end
            S_SCAN: begin
                if (step_reg == (STEP_W'(count_reg) << 1)) begin
                    res_st_next = ST_PINNED;
                    state_next  = S_FINISH;
                end else if (!head.pinned && !head.accessed) begin
                    // victim leaves the list
                    shctl.shift   = 1'b1;
                    count_next    = count_reg - 1'b1;
                    res_slot_next = head.slot;
                    res_ev_next   = 1'b1;
                    res_page_next = head.page;
                    res_wb_next   = head.mapped && head.dirty;
                    res_sw_next   = !head.mapped;
                    if (head.slot == start_reg) begin
                        start_next = second.slot;
                    end
                    state_next = S_RESTORE;
                end else begin
                    if (!head.pinned) begin
                        kept.accessed = 1'b0;
                    end
                    shctl.shift    = 1'b1;
                    shctl.load     = 1'b1;
                    shctl.load_idx = SLOT_W'(count_reg - 1'b1);
                    shctl.ins      = kept;
                    step_next      = step_reg + 1'b1;
                end
            end
            S_RESTORE: begin
                // rotate back to the original oldest, then append
                if (head.slot == start_reg) begin
                    shctl.load     = 1'b1;
                    shctl.load_idx = count_reg[SLOT_W-1:0];
                    shctl.ins      = fresh;
                    shctl.ins.slot = res_slot_reg;
                    count_next     = count_reg + 1'b1;
                    state_next     = S_FINISH;
                end else begin
                    shctl.shift    = 1'b1;
                    shctl.load     = 1'b1;
                    shctl.load_idx = SLOT_W'(count_reg - 1'b1);
                end
            end
            S_ROTATE: begin
                if (step_reg == STEP_W'(rot_len_reg)) begin
                    state_next = S_FINISH;
                end else begin
                    step_next   = step_reg + 1'b1;
                    shctl.shift = 1'b1;
                    if ((head.slot == slot_reg) && (act_reg == ACT_FREE)) begin
                        count_next          = count_reg - 1'b1;
                        used_next[slot_reg] = 1'b0;
                    end else begin
                        if (head.slot == slot_reg) begin
                            if (act_reg == ACT_ACCESS) begin
                                kept.accessed = 1'b1;
                                kept.dirty    = head.dirty | wr_reg;
                            end else begin
                                kept.pinned = pin_reg;
                            end
                        end
                        shctl.load     = 1'b1;
                        shctl.load_idx = SLOT_W'(count_reg - 1'b1);
                        shctl.ins      = kept;
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_st_reg;
                    m_data_next  = {3'b000, res_sw_reg, res_wb_reg, res_page_reg,
                                    res_ev_reg, res_slot_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        slot_reg     <= slot_next;
        page_reg     <= page_next;
        fm_reg       <= fm_next;
        wr_reg       <= wr_next;
        pin_reg      <= pin_next;
        step_reg     <= step_next;
        rot_len_reg  <= rot_len_next;
        start_reg    <= start_next;
        fcnt_reg     <= fcnt_next;
        res_st_reg   <= res_st_next;
        res_slot_reg <= res_slot_next;
        res_ev_reg   <= res_ev_next;
        res_page_reg <= res_page_next;
        res_wb_reg   <= res_wb_next;
        res_sw_reg   <= res_sw_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `PSTC_ASSERT(a_count_range, count_reg <= CNT_W'(FRAMES))
    `PSTC_ASSERT(a_list_matches_used,
        state_reg == S_IDLE |-> CNT_W'($countones(used_reg)) == count_reg)
    `PSTC_ASSERT(a_scan_bound,
        state_reg == S_SCAN |-> step_reg <= (STEP_W'(count_reg) << 1))
    `PSTC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready)

endmodule

// File: design/pinned_second_chance_frame_table.sv
// Pinned second-chance frame table.
// Input channel s_*: one word per request. s_tuser carries the action
// (allocate, free, access, pin); s_tdata carries slot, page and flags.
// Result channel m_*: exactly one word per request, in request order.
// m_tuser carries the status, m_tdata the grant and eviction details.
// The age list lives in a row of cells that rotates one step a cycle
// through the control unit, which edits the head entry as it passes.
// Allocate with a free slot sweeps up from slot 0 to the lowest free slot;
// free, access and pin rotate the list once through every resident frame;
// eviction takes up to 2 x FRAMES scan steps plus up to FRAMES steps to
// rotate the list back. One request is in flight.
// Reset (aresetn low, synchronous) empties the table: no frames in use.
// A stalled receiver holds the result in the output register; the next
// request is still taken and processed, and waits only to hand over.
module pinned_second_chance_frame_table
    import pstc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] slot, [25:6] page, [26] file_mapped, [27] is_write,
    // [28] pin_value, [31:29] zero
    input  logic [31:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] granted_slot, [6] evicted, [26:7] victim_page, [27] write_back,
    // [28] to_swap, [31:29] zero
    output logic [31:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    pstc_shift_t shctl;
    pstc_entry_t ent [FRAMES];

    pstc_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .head     (ent[0]),
        .second   (ent[1]),
        .shctl    (shctl)
    );

    // cell i holds age position i; oldest at cell 0
    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        pstc_entry_t right;
        if (i == FRAMES - 1) begin : g_last
            assign right = shctl.ins;
        end else begin : g_mid
            assign right = ent[i+1];
        end
        pstc_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (SLOT_W'(i)),
            .ctl       (shctl),
            .right_in  (right),
            .entry_out (ent[i])
        );
    end

endmodule

// File: sim/frame_table_checker.sv
module frame_table_checker
    import pstc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_words
);

    typedef struct packed {
        logic [1:0]           status;
        logic [SLOT_W-1:0]    granted;
        logic                 evicted;
        logic [PAGE_BITS-1:0] victim;
        logic                 write_back;
        logic                 to_swap;
    } grant_t;

    logic                 used [FRAMES];
    logic                 pinned [FRAMES];
    logic                 accessed [FRAMES];
    logic                 dirty [FRAMES];
    logic                 mapped [FRAMES];
    logic [PAGE_BITS-1:0] page_tag [FRAMES];
    int                   age_list [$];
    grant_t               grants_due [$];

    function automatic void install_frame(int s, logic [PAGE_BITS-1:0] pg, logic fm);
        used[s] = 1'b1;
        pinned[s] = 1'b0;
        accessed[s] = 1'b0;
        dirty[s] = 1'b0;
        mapped[s] = fm;
        page_tag[s] = pg;
        age_list.push_back(s);
    endfunction

    function automatic grant_t run_request(logic [1:0] act, logic [31:0] d);
        grant_t g;
        int s;
        int pos;
        int steps;
        logic [SLOT_W-1:0] sl;
        logic [PAGE_BITS-1:0] pg;
        g = '0;
        sl = d[5:0];
        pg = d[25:6];
        if (act == ACT_ALLOC) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (!used[i]) begin
                    install_frame(i, pg, d[26]);
                    g.granted = SLOT_W'(i);
                    return g;
                end
            end
            // second chance from the oldest entry, two passes at most
            steps = 2 * age_list.size();
            pos = 0;
            for (int i = 0; i < steps; i++) begin
                s = age_list[pos];
                if (!pinned[s]) begin
                    if (accessed[s]) begin
                        accessed[s] = 1'b0;
                    end else begin
                        g.granted = SLOT_W'(s);
                        g.evicted = 1'b1;
                        g.victim = page_tag[s];
                        g.write_back = mapped[s] && dirty[s];
                        g.to_swap = !mapped[s];
                        age_list.delete(pos);
                        install_frame(s, pg, d[26]);
                        return g;
                    end
                end
                pos++;
                if (pos >= age_list.size()) pos = 0;
            end
            g.status = ST_PINNED;
            return g;
        end
        if (!used[sl]) begin
            g.status = ST_UNUSED;
            return g;
        end
        case (act)
            ACT_FREE: begin
                foreach (age_list[i]) begin
                    if (age_list[i] == sl) begin
                        age_list.delete(i);
                        break;
                    end
                end
                used[sl] = 1'b0;
                pinned[sl] = 1'b0;
                accessed[sl] = 1'b0;
                dirty[sl] = 1'b0;
            end
            ACT_ACCESS: begin
                accessed[sl] = 1'b1;
                if (d[27]) dirty[sl] = 1'b1;
            end
            default: pinned[sl] = d[28];
        endcase
        return g;
    endfunction

    assign pending_words = grants_due.size();

    always @(posedge aclk) begin
        grant_t exp_g;
        grant_t got;
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                used[i] = 1'b0;
                pinned[i] = 1'b0;
                accessed[i] = 1'b0;
                dirty[i] = 1'b0;
            end
            age_list.delete();
            grants_due.delete();
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[5:0], m_tdata[6], m_tdata[26:7], m_tdata[27],
                       m_tdata[28]};
                if (grants_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_g = grants_due.pop_front();
                    if (got != exp_g || m_tdata[31:29] != 3'd0) begin
                        fail_count <= fail_count + 1;
                        if (got.status != exp_g.status)
                            $error("status exp %0d got %0d", exp_g.status, got.status);
                        if (got.granted != exp_g.granted)
                            $error("granted_slot exp %0d got %0d", exp_g.granted,
                                   got.granted);
                        if (got.evicted != exp_g.evicted)
                            $error("evicted exp %0d got %0d", exp_g.evicted, got.evicted);
                        if (got.victim != exp_g.victim)
                            $error("victim_page exp %0h got %0h", exp_g.victim, got.victim);
                        if (got.write_back != exp_g.write_back)
                            $error("write_back exp %0d got %0d", exp_g.write_back,
                                   got.write_back);
                        if (got.to_swap != exp_g.to_swap)
                            $error("to_swap exp %0d got %0d", exp_g.to_swap,
                                   got.to_swap);
                        if (m_tdata[31:29] != 3'd0)
                            $error("pad exp 0 got %0d", m_tdata[31:29]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(run_request(s_tuser, s_tdata));
        end
    end

endmodule

// File: sim/tb.sv
module tb
    import pstc_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending_words;
    int          idle_cycles;
    bit          hold_off;      // long receiver hold-off request
    bit          slots_live [FRAMES];  // tb's rough view of allocated slots

    localparam int IDLE_LIMIT = 20000;

    pinned_second_chance_frame_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // [5:0] slot, [25:6] page, [26] file_mapped,
                             // [27] is_write, [28] pin_value
        .s_tuser(s_tuser),   // [1:0] action
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // [5:0] granted_slot, [6] evicted, [26:7] victim_page,
                             // [27] write_back, [28] to_swap
        .m_tuser(m_tuser)    // [1:0] status
    );

    frame_table_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: own stall pattern; a hold-off forces tready low
    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_off)
                m_tready <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                m_tready <= 1'b1;                    // no-stall stretch
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(logic [1:0] act, logic [5:0] sl, logic [19:0] pg,
                             logic fm, logic wr, logic pv);
        s_tuser  <= act;
        s_tdata  <= {3'd0, pv, wr, fm, pg, sl};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
    endtask

    // random request: mostly slots likely in use, sometimes any slot
    task automatic random_word(int alloc_pct);
        logic [1:0] act;
        logic [5:0] sl;
        act = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC
              : 2'($urandom_range(1, 3));
        sl = 6'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 8 && !slots_live[sl]; k++) sl = 6'($urandom);
        end
        if (act == ACT_FREE && slots_live[sl]) slots_live[sl] = 1'b0;
        send_word(act, sl, 20'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ALLOC;
        hold_off = 1'b0;
        aresetn  = 1'b0;
        foreach (slots_live[i]) slots_live[i] = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: unused-slot cases on an empty table, field extremes
        send_word(ACT_FREE, 6'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_ACCESS, 6'd63, 20'hFFFFF, 1'b1, 1'b1, 1'b1);
        send_word(ACT_PIN, 6'd63, 20'd0, 1'b0, 1'b0, 1'b1);
        send_word(ACT_ALLOC, 6'd63, 20'hFFFFF, 1'b1, 1'b1, 1'b1);
        send_word(ACT_ALLOC, 6'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_ACCESS, 6'd0, 20'd0, 1'b0, 1'b1, 1'b0);
        send_word(ACT_PIN, 6'd1, 20'd0, 1'b0, 1'b0, 1'b1);
        send_word(ACT_PIN, 6'd1, 20'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_FREE, 6'd1, 20'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_FREE, 6'd1, 20'd0, 1'b0, 1'b0, 1'b0);   // now unused

        // fill the table while the receiver holds off, so the input stalls
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 63; i++)
                send_word(ACT_ALLOC, 6'd0, 20'($urandom), 1'(i % 2), 1'b0, 1'b0);
        join
        foreach (slots_live[i]) slots_live[i] = 1'b1;
        drain();

        // pin everything: allocation must report all pinned
        for (int i = 0; i < FRAMES; i++)
            send_word(ACT_PIN, 6'(i), 20'd0, 1'b0, 1'b0, 1'b1);
        send_word(ACT_ALLOC, 6'd0, 20'h12345, 1'b0, 1'b0, 1'b0);
        // unpin a few and dirty them so evictions hit write-back and swap
        for (int i = 0; i < 8; i++) begin
            send_word(ACT_PIN, 6'(i), 20'd0, 1'b0, 1'b0, 1'b0);
            send_word(ACT_ACCESS, 6'(i), 20'd0, 1'b0, 1'b1, 1'b0);
        end
        for (int i = 0; i < 10; i++)
            send_word(ACT_ALLOC, 6'd0, 20'($urandom), 1'($urandom), 1'b0, 1'b0);
        drain();
        for (int i = 0; i < FRAMES; i++)
            send_word(ACT_PIN, 6'(i), 20'd0, 1'b0, 1'b0, 1'b0);

        // random bursts: full-table phases favour evictions, others churn
        for (int b = 0; b < 60; b++) begin
            int len;
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                random_word((b % 4 == 0) ? 60 : 35);
            if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 30));
        end
        drain();
        for (int b = 0; b < 45; b++) begin
            int len;
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
                random_word((b % 3 == 0) ? 70 : 40);
            if (b % 2 == 0) gap($urandom_range(0, 15));
        end

        drain();
        repeat (400) @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
